// ===== sv/scff_pkg.sv =====
// ----------------------------------------------------------------------------
// scff_pkg
// Shared types, codes and constants of the shift-chain frame forwarder.
// ----------------------------------------------------------------------------
package scff_pkg;

    // Input mode codes as they arrive from the host side.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_ECHO  = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;

    // Try number at which one test pattern is given up.
    localparam logic [7:0] TRY_LIMIT   = 8'd255;
    localparam logic [7:0] FAIL_LENGTH = 8'd255;

    localparam logic [7:0] PATTERN_0 = 8'h55;
    localparam logic [7:0] PATTERN_1 = 8'h33;
    localparam logic [7:0] PATTERN_2 = 8'h0F;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Operation decided by the front end from the mode field alone.
    typedef enum logic [1:0] {
        OP_START,
        OP_ECHO,
        OP_DATA,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic       spi_send;
        logic [7:0] spi_byte;
        logic       ack_send;
        logic       latch_pulse;
        logic       detect_done;
        logic [7:0] chain_length;
        logic       item_ignored;
    } result_t;

    function automatic logic [7:0] pattern_of(input logic [1:0] step);
        logic [7:0] p;
        unique case (step)
            2'd0:    p = PATTERN_0;
            2'd1:    p = PATTERN_1;
            default: p = PATTERN_2;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/scff_in_if.sv =====
// ----------------------------------------------------------------------------
// scff_in_if
// Input channel: mode and data byte with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scff_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// ===== sv/scff_out_if.sv =====
// ----------------------------------------------------------------------------
// scff_out_if
// Result channel: SPI, acknowledge, latch and detection results.
// ----------------------------------------------------------------------------
interface scff_out_if;
    logic       valid;
    logic       ready;
    logic       spi_send;
    logic [7:0] spi_byte;
    logic       ack_send;
    logic       latch_pulse;
    logic       detect_done;
    logic [7:0] chain_length;
    logic       item_ignored;

    modport source (
        output valid, output spi_send, output spi_byte, output ack_send,
        output latch_pulse, output detect_done, output chain_length,
        output item_ignored, input ready
    );
    modport sink (
        input valid, input spi_send, input spi_byte, input ack_send,
        input latch_pulse, input detect_done, input chain_length,
        input item_ignored, output ready
    );
endinterface

// ===== sv/scff_front.sv =====
// ----------------------------------------------------------------------------
// scff_front
// Accepts input transactions and classifies them into operations.
// ----------------------------------------------------------------------------
module scff_front (
    scff_in_if.sink          items,
    output logic             push_valid,
    input  logic             push_ready,
    output scff_pkg::cmd_t   push_data
);
    import scff_pkg::*;

    op_t op;

    always_comb
    begin
        unique case (items.mode)
            MODE_START: op = OP_START;
            MODE_ECHO:  op = OP_ECHO;
            MODE_DATA:  op = OP_DATA;
            default:    op = OP_BAD;
        endcase
    end

    assign push_valid          = items.valid;
    assign items.ready         = push_ready;
    assign push_data.op        = op;
    assign push_data.data_byte = items.data_byte;

endmodule

// ===== sv/scff_queue.sv =====
// ----------------------------------------------------------------------------
// scff_queue
// Small first-in first-out queue of classified operations.
// ----------------------------------------------------------------------------
module scff_queue #(
    parameter int DEPTH = scff_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  scff_pkg::cmd_t   push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output scff_pkg::cmd_t   pop_data
);
    import scff_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/scff_back.sv =====
// ----------------------------------------------------------------------------
// scff_back
// Executes operations: auto-detect sequencing, frame counting and results.
// ----------------------------------------------------------------------------
module scff_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  scff_pkg::cmd_t   pop_data,
    scff_out_if.source       results
);
    import scff_pkg::*;

    typedef enum logic {
        PH_RUN,
        PH_DETECT
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] step_reg, step_next;
    logic [7:0] try_reg, try_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    result_t    res_reg, res_next;

    logic       take;
    logic [1:0] step_cur;
    logic [7:0] try_inc;
    logic [7:0] pos_inc;
    logic       finish;
    logic [7:0] fin_count;

    assign pop_ready = !valid_reg || results.ready;
    assign take      = pop_valid && pop_ready;
    assign step_cur  = (step_reg > 2'd2) ? 2'd2 : step_reg;
    assign try_inc   = try_reg + 8'd1;
    assign pos_inc   = pos_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        try_next    = try_reg;
        first_next  = first_reg;
        second_next = second_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        res_next    = '0;
        finish      = 1'b0;
        fin_count   = try_reg;

        if (take)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && !results.ready;
        end

        if (take)
        begin
            priority if (pop_data.op == OP_START)
            begin
                phase_next        = PH_DETECT;
                step_next         = 2'd0;
                try_next          = 8'd1;
                res_next.spi_send = 1'b1;
                res_next.spi_byte = PATTERN_0;
            end
            else if (pop_data.op == OP_ECHO && phase_reg == PH_DETECT)
            begin
                step_next = step_cur;
                if (pop_data.data_byte == pattern_of(step_cur))
                begin
                    finish    = 1'b1;
                    fin_count = try_reg;
                end
                else if (try_inc >= TRY_LIMIT)
                begin
                    finish    = 1'b1;
                    fin_count = TRY_LIMIT;
                end
                else
                begin
                    try_next          = try_inc;
                    res_next.spi_send = 1'b1;
                    res_next.spi_byte = pattern_of(step_cur);
                end
            end
            else if (pop_data.op == OP_DATA && phase_reg == PH_RUN)
            begin
                res_next.spi_send = 1'b1;
                res_next.spi_byte = pop_data.data_byte;
                // A frame length of zero matches only after the counter wraps.
                if (pos_inc == length_reg)
                begin
                    pos_next             = 8'd0;
                    res_next.ack_send    = 1'b1;
                    res_next.latch_pulse = 1'b1;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            else
            begin
                res_next.item_ignored = 1'b1;
            end

            if (finish)
            begin
                unique case (step_cur)
                    2'd0:
                    begin
                        first_next        = fin_count;
                        step_next         = 2'd1;
                        try_next          = 8'd1;
                        res_next.spi_send = 1'b1;
                        res_next.spi_byte = PATTERN_1;
                    end
                    2'd1:
                    begin
                        second_next       = fin_count;
                        step_next         = 2'd2;
                        try_next          = 8'd1;
                        res_next.spi_send = 1'b1;
                        res_next.spi_byte = PATTERN_2;
                    end
                    default:
                    begin
                        if (first_reg == second_reg && second_reg == fin_count)
                        begin
                            length_next = fin_count;
                        end
                        else
                        begin
                            length_next = FAIL_LENGTH;
                        end
                        pos_next              = 8'd0;
                        step_next             = 2'd0;
                        try_next              = 8'd0;
                        phase_next            = PH_RUN;
                        res_next.detect_done  = 1'b1;
                        res_next.chain_length = length_next;
                    end
                endcase
            end
        end
        else
        begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RUN;
            step_reg   <= 2'd0;
            try_reg    <= 8'd0;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
            length_reg <= 8'd0;
            pos_reg    <= 8'd0;
            valid_reg  <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            try_reg    <= try_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            valid_reg  <= valid_next;
            res_reg    <= res_next;
        end
    end

    assign results.valid        = valid_reg;
    assign results.spi_send     = res_reg.spi_send;
    assign results.spi_byte     = res_reg.spi_byte;
    assign results.ack_send     = res_reg.ack_send;
    assign results.latch_pulse  = res_reg.latch_pulse;
    assign results.detect_done  = res_reg.detect_done;
    assign results.chain_length = res_reg.chain_length;
    assign results.item_ignored = res_reg.item_ignored;

endmodule

// ===== sv/shift_chain_frame_forwarder_top.sv =====
// ----------------------------------------------------------------------------
// shift_chain_frame_forwarder_top
// Frame forwarder and chain-length auto-detect for a display shift chain.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction, in order.
// The block takes one transaction per cycle while the result side keeps up;
// each result is registered by the execution stage after its input has passed
// through the queue. The rate is set by the execution stage, which updates the
// detect and frame-counter state once per operation. A queue of QUEUE_DEPTH
// entries between the classifying front end and the execution stage absorbs
// stalls on the result side, so input stays ready until that queue fills.
// After reset the block is in run mode with a frame length of 256 bytes.
module shift_chain_frame_forwarder_top #(
    parameter int QUEUE_DEPTH = scff_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    scff_in_if.sink     items,
    scff_out_if.source  results
);
    import scff_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    scff_front u_front (
        .items      (items),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    scff_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    scff_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .results   (results)
    );

    // A dropped transaction carries no other indication.
    a_ignored_alone : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.item_ignored |->
            !results.spi_send && !results.ack_send && !results.latch_pulse
            && !results.detect_done)
        else $error("ignored transaction carries other flags");

    // End of frame always comes with the last data byte being shifted.
    a_ack_with_latch : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ack_send |->
            results.latch_pulse && results.spi_send && !results.detect_done)
        else $error("acknowledge without latch or data byte");

    // A finished detection reports a length of at least one try.
    a_length_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.detect_done |->
            results.chain_length != 8'd0 && !results.spi_send)
        else $error("detect result with zero length or a send");

    a_length_only_on_done : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.detect_done |-> results.chain_length == 8'd0)
        else $error("chain length outside a detect result");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shift-chain frame forwarder. Host transactions
// (detect starts, echoed bytes, data bytes and junk) go in through a bursty
// driver. A transaction-level model of the detect and frame-counter logic predicts
// one result per accepted transaction. A monitor with its own stall pattern
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scff_pkg::*;

    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam logic [23:0] TEST_PATTERNS = {PATTERN_2, PATTERN_1, PATTERN_0};
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_ITEMS  = 1000;

    typedef enum logic {
        PH_RUN,
        PH_DETECT
    } fw_phase_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } host_item_t;

    logic clk;
    logic rst_n;

    scff_in_if  item_ch ();
    scff_out_if result_ch ();

    shift_chain_frame_forwarder_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch)
    );

    host_item_t pending_items[$];
    result_t    expected_results[$];

    // Model state of the forwarder.
    fw_phase_t  fw_phase;
    logic [1:0] fw_step;
    logic [7:0] fw_tries;
    logic [7:0] fw_first;
    logic [7:0] fw_second;
    logic [7:0] fw_frame_len;
    logic [7:0] fw_byte_pos;

    int errors;
    int cycle_count;
    int burst_left;
    int gap_left;
    int hold_left;
    int stall_style;
    int counted_items;

    always #5 clk = ~clk;

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
        begin
            report_error($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic result_t forward_step(input logic [1:0] mode,
                                             input logic [7:0] byte_in);
        result_t    r;
        logic       closed;
        logic [7:0] count;
        r      = '0;
        closed = 1'b0;
        count  = fw_tries;
        if (mode == MODE_START)
        begin
            fw_phase   = PH_DETECT;
            fw_step    = 2'd0;
            fw_tries   = 8'd1;
            r.spi_send = 1'b1;
            r.spi_byte = PATTERN_0;
        end
        else if (mode == MODE_ECHO && fw_phase == PH_DETECT)
        begin
            if (byte_in == TEST_PATTERNS[8*fw_step +: 8])
            begin
                closed = 1'b1;
            end
            else
            begin
                fw_tries = fw_tries + 8'd1;
                if (fw_tries >= TRY_LIMIT)
                begin
                    closed = 1'b1;
                    count  = TRY_LIMIT;
                end
                else
                begin
                    r.spi_send = 1'b1;
                    r.spi_byte = TEST_PATTERNS[8*fw_step +: 8];
                end
            end
        end
        else if (mode == MODE_DATA && fw_phase == PH_RUN)
        begin
            r.spi_send  = 1'b1;
            r.spi_byte  = byte_in;
            fw_byte_pos = fw_byte_pos + 8'd1;
            // A frame length of zero matches only after the counter wraps.
            if (fw_byte_pos == fw_frame_len)
            begin
                fw_byte_pos   = 8'd0;
                r.ack_send    = 1'b1;
                r.latch_pulse = 1'b1;
            end
        end
        else
        begin
            r.item_ignored = 1'b1;
        end

        if (closed)
        begin
            if (fw_step != 2'd2)
            begin
                if (fw_step == 2'd0)
                    fw_first = count;
                else
                    fw_second = count;
                fw_step    = fw_step + 2'd1;
                fw_tries   = 8'd1;
                r.spi_send = 1'b1;
                r.spi_byte = TEST_PATTERNS[8*fw_step +: 8];
            end
            else
            begin
                fw_frame_len   = (fw_first == fw_second && fw_second == count) ?
                                 count : FAIL_LENGTH;
                fw_byte_pos    = 8'd0;
                fw_step        = 2'd0;
                fw_tries       = 8'd0;
                fw_phase       = PH_RUN;
                r.detect_done  = 1'b1;
                r.chain_length = fw_frame_len;
            end
        end
        return r;
    endfunction

    task automatic add_item(input logic [1:0] mode, input logic [7:0] b,
                            input bit counts);
        host_item_t it;
        it.mode      = mode;
        it.data_byte = b;
        pending_items.push_back(it);
        if (counts)
            counted_items++;
    endtask

    task automatic add_noise();
        if ($urandom_range(0, 1) == 0)
            add_item(MODE_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
        else
            add_item(($urandom_range(0, 1) == 0) ? MODE_ECHO : MODE_DATA,
                     8'($urandom_range(0, 255)), 1'b0);
    endtask

    // A count of c means c-1 wrong echoes, then the pattern itself. A count at
    // the try limit gives up without ever seeing the pattern.
    task automatic add_detect(input int c0, input int c1, input int c2,
                              input bit noisy);
        int         counts[3];
        logic [7:0] pat;
        logic [7:0] b;
        counts[0] = c0;
        counts[1] = c1;
        counts[2] = c2;
        add_item(MODE_START, 8'($urandom_range(0, 255)), 1'b1);
        for (int p = 0; p < 3; p++)
        begin
            pat = TEST_PATTERNS[8*p +: 8];
            for (int t = 1; t < counts[p] && t < int'(TRY_LIMIT); t++)
            begin
                b = 8'($urandom_range(0, 255));
                while (b == pat)
                    b = 8'($urandom_range(0, 255));
                add_item(MODE_ECHO, b, 1'b1);
                if (noisy && $urandom_range(0, 11) == 0)
                    add_noise();
            end
            if (counts[p] < int'(TRY_LIMIT))
                add_item(MODE_ECHO, pat, 1'b1);
        end
    endtask

    task automatic add_data_run(input int len);
        for (int i = 0; i < len; i++)
        begin
            add_item(MODE_DATA, 8'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 15) == 0)
                add_noise();
        end
    endtask

    // Driver: predicts each accepted transaction, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid     <= 1'b0;
            item_ch.mode      <= MODE_START;
            item_ch.data_byte <= 8'd0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_results.push_back(forward_step(item_ch.mode,
                                                        item_ch.data_byte));
                pending_items.delete(0);
            end
            if (item_ch.valid && !item_ch.ready)
            begin
                // Offer stays on the bus until it is taken.
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                item_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item_ch.valid     <= 1'b1;
                item_ch.mode      <= pending_items[0].mode;
                item_ch.data_byte <= pending_items[0].data_byte;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 9) == 0) ?
                                 $urandom_range(50, 200) : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                                 $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction and sets the next ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_error("result with no transaction outstanding");
                end
                else
                begin
                    check_field("spi_send", result_ch.spi_send,
                                expected_results[0].spi_send);
                    check_field("spi_byte", result_ch.spi_byte,
                                expected_results[0].spi_byte);
                    check_field("ack_send", result_ch.ack_send,
                                expected_results[0].ack_send);
                    check_field("latch_pulse", result_ch.latch_pulse,
                                expected_results[0].latch_pulse);
                    check_field("detect_done", result_ch.detect_done,
                                expected_results[0].detect_done);
                    check_field("chain_length", result_ch.chain_length,
                                expected_results[0].chain_length);
                    check_field("item_ignored", result_ch.item_ignored,
                                expected_results[0].item_ignored);
                    expected_results.delete(0);
                end
            end
            if (cycle_count % 64 == 0)
                stall_style = $urandom_range(0, 3);
            case (stall_style)
                0:       result_ch.ready <= (hold_left == 0);
                1:       result_ch.ready <= (hold_left == 0) &&
                                            ($urandom_range(0, 1) == 0);
                2:       result_ch.ready <= (hold_left == 0) &&
                                            ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= (hold_left == 0) &&
                                            ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Long receiver hold-offs so the internal queue fills and input stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (cycle_count == 400 || cycle_count == 4000)
            hold_left <= 300;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("shift_chain_frame_forwarder_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.mode      = MODE_START;
        item_ch.data_byte = 8'd0;
        result_ch.ready   = 1'b0;
        errors            = 0;
        cycle_count       = 0;
        burst_left        = 0;
        gap_left          = 0;
        stall_style       = 0;
        counted_items     = 0;
        fw_phase          = PH_RUN;
        fw_step           = 2'd0;
        fw_tries          = 8'd0;
        fw_first          = 8'd0;
        fw_second         = 8'd0;
        fw_frame_len      = 8'd0;
        fw_byte_pos       = 8'd0;

        // Run phase after reset: junk, a stray echo, extreme data bytes.
        add_item(MODE_UNUSED, 8'hFF, 1'b0);
        add_item(MODE_ECHO, PATTERN_0, 1'b0);
        add_item(MODE_DATA, 8'h00, 1'b1);
        add_item(MODE_DATA, 8'hFF, 1'b1);
        // Finish the default 256-byte frame and run a few bytes past the wrap.
        add_data_run(258);

        // Counts disagree (1, 2, 1) with junk during detection: length fails.
        add_item(MODE_START, 8'h00, 1'b1);
        add_item(MODE_DATA, 8'h12, 1'b0);
        add_item(MODE_UNUSED, 8'h00, 1'b0);
        add_item(MODE_ECHO, PATTERN_0, 1'b1);
        add_item(MODE_ECHO, 8'hAA, 1'b1);
        add_item(MODE_ECHO, PATTERN_1, 1'b1);
        add_item(MODE_ECHO, PATTERN_2, 1'b1);

        // Restart in the middle, then a one-byte frame.
        add_item(MODE_START, 8'h00, 1'b1);
        add_item(MODE_ECHO, PATTERN_0, 1'b1);
        add_item(MODE_START, 8'hFF, 1'b1);
        add_detect(1, 1, 1, 1'b0);
        add_item(MODE_DATA, 8'h80, 1'b1);
        add_item(MODE_DATA, 8'h7F, 1'b1);

        // Two-byte frame.
        add_detect(2, 2, 2, 1'b0);
        add_data_run(3);

        // First pattern gives up at the try limit.
        add_detect(TRY_LIMIT, 3, 3, 1'b1);
        add_data_run(10);

        while (counted_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    int k;
                    k = $urandom_range(1, 8);
                    case ($urandom_range(0, 7))
                        6:       add_detect($urandom_range(1, 4), $urandom_range(1, 4),
                                            $urandom_range(1, 4), 1'b1);
                        7:       begin
                                     k = $urandom_range(9, 40);
                                     add_detect(k, k, k, 1'b1);
                                 end
                        default: add_detect(k, k, k, 1'b1);
                    endcase
                end
                4, 5, 6, 7:
                begin
                    add_data_run($urandom_range(1, 40));
                end
                8:
                begin
                    // Detection cut short by a fresh start.
                    add_item(MODE_START, 8'($urandom_range(0, 255)), 1'b1);
                    repeat ($urandom_range(0, 5))
                        add_item(MODE_ECHO, 8'($urandom_range(0, 255)), 1'b1);
                    add_detect($urandom_range(1, 6), $urandom_range(1, 6),
                               $urandom_range(1, 6), 1'b0);
                end
                default:
                begin
                    repeat ($urandom_range(1, 3))
                        add_noise();
                end
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("shift_chain_frame_forwarder_top regression: pass");
        else
            $display("shift_chain_frame_forwarder_top regression: fail");
        $finish;
    end

endmodule
